// ----- rtl/gge_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gge_pkg
// Shared widths, constant tables and types of the Griewank evaluator.
// ----------------------------------------------------------------------------
package gge_pkg;

    localparam int MAX_DIM    = 64;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 27;
    localparam int MAG_W      = 27;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int SUM_W      = 48;
    localparam int OUT_W      = 29;
    localparam int HORNER_LEN = 5;

    // The divide by 4000 is a shift by five followed by a divide by 125, done
    // in 16-bit digits with a reciprocal that is exact for every digit step.
    localparam int               SUM_SHIFT   = 5;
    localparam int               DIV_CHUNKS  = 3;
    localparam logic [6:0]       SUM_ODD_DIV = 7'd125;
    localparam logic [23:0]      SUM_RECIP   = 24'd8589935;

    localparam logic [CNT_W-1:0] NUM_DIM_RESET = 7'd10;
    localparam logic [30:0]      Q30_ONE       = 31'h4000_0000;
    localparam logic [31:0]      HALF_PI_Q30   = 32'd1686629713;
    localparam logic [31:0]      INV_TWO_PI    = 32'd683565276;
    localparam logic [39:0]      OUT_MAX       = 40'h00_1FFF_FFFF;

    typedef logic [HORNER_LEN-1:0][6:0]  div_tab_t;
    typedef logic [HORNER_LEN-1:0][31:0] recip_tab_t;
    typedef logic [MAX_DIM-1:0][30:0]    rsqrt_tab_t;

    localparam div_tab_t COS_DIV = {7'd2, 7'd12, 7'd30, 7'd56, 7'd90};
    localparam div_tab_t SIN_DIV = {7'd6, 7'd20, 7'd42, 7'd72, 7'd110};

    localparam recip_tab_t COS_RECIP = {
        32'((64'd1 << 32) / 2),  32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 30),
        32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 90)};
    localparam recip_tab_t SIN_RECIP = {
        32'((64'd1 << 32) / 6),  32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 42),
        32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 110)};

    function automatic logic [30:0] isqrt_q60(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int k = 30; k >= 0; k--)
        begin
            cand = res | (64'd1 << k);
            if (cand * cand <= v)
            begin
                res = cand;
            end
        end
        return res[30:0];
    endfunction

    function automatic rsqrt_tab_t build_rsqrt_rom();
        rsqrt_tab_t tab;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            tab[i] = isqrt_q60((64'd1 << 60) / 64'(i + 1));
        end
        return tab;
    endfunction

    localparam rsqrt_tab_t RSQRT_ROM = build_rsqrt_rom();

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [IDX_W-1:0] idx;
        logic             last;
    } gge_job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ANG,
        ST_PH,
        ST_TH,
        ST_T2,
        ST_HMUL,
        ST_HREC,
        ST_HBACK,
        ST_HFIX,
        ST_SMUL,
        ST_SIN,
        ST_PROD,
        ST_DIV,
        ST_OUT
    } gge_state_t;

endpackage
`default_nettype wire

// ----- rtl/gge_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gge_channels
// Valid/ready channels for coordinates, results and the configuration write.
// ----------------------------------------------------------------------------
interface gge_coord_if import gge_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coordinate;
    modport source (output valid, output coordinate, input ready);
    modport sink (input valid, input coordinate, output ready);
endinterface

interface gge_result_if import gge_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] objective_value;
    modport source (output valid, output objective_value, input ready);
    modport sink (input valid, input objective_value, output ready);
endinterface

interface gge_cfg_if import gge_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] num_dimensions;
    modport source (output valid, output num_dimensions, input ready);
    modport sink (input valid, input num_dimensions, output ready);
endinterface
`default_nettype wire

// ----- rtl/gge_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gge_front
// Accepts coordinates, tracks the position in the vector and marks the last one.
// ----------------------------------------------------------------------------
module gge_front import gge_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    gge_coord_if.sink     coord,
    gge_cfg_if.sink       cfg,
    input  wire logic     queue_full,
    output logic          push,
    output gge_job_t      job
);

    logic [CNT_W-1:0] num_dim_reg;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [CNT_W-1:0] n_eff;
    logic [MAG_W-1:0] neg_coord;

    assign cfg.ready   = 1'b1;
    assign coord.ready = !queue_full;
    assign push        = coord.valid && coord.ready;

    always_comb
    begin
        if (num_dim_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (num_dim_reg > CNT_W'(MAX_DIM))
        begin
            n_eff = CNT_W'(MAX_DIM);
        end
        else
        begin
            n_eff = num_dim_reg;
        end
    end

    assign neg_coord = MAG_W'(~coord.coordinate) + MAG_W'(1);
    assign job.mag   = coord.coordinate[COORD_W-1] ? neg_coord : MAG_W'(coord.coordinate);
    assign job.idx   = index_reg;
    assign job.last  = ({1'b0, index_reg} + CNT_W'(1)) >= n_eff;
    assign index_next = job.last ? '0 : index_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dim_reg <= NUM_DIM_RESET;
            index_reg   <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                num_dim_reg <= cfg.num_dimensions;
            end
            if (push)
            begin
                index_reg <= index_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/gge_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gge_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module gge_queue import gge_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire gge_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          job_valid,
    output gge_job_t      job
);

    gge_job_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = count_reg == 2'd2;
    assign job_valid = count_reg != 2'd0;
    assign job       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && job_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/gge_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gge_back
// Sequencer around one shared 32x32 multiplier: square, scaled angle, cosine
// and sine series, product update and the final divide by 4000.
// ----------------------------------------------------------------------------
module gge_back import gge_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_valid,
    input  wire gge_job_t job,
    output logic          pop,
    gge_result_if.source  result
);

    gge_state_t       state_reg, state_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_reg, last_next;
    logic [63:0]      prod_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [30:0]      cp_mag_reg, cp_mag_next;
    logic             cp_neg_reg, cp_neg_next;
    logic [1:0]       quad_reg, quad_next;
    logic             swap_reg, swap_next;
    logic [29:0]      th_reg, th_next;
    logic [29:0]      t2_reg, t2_next;
    logic [30:0]      h_reg, h_next;
    logic [29:0]      m_reg, m_next;
    logic [31:0]      q0_reg, q0_next;
    logic [2:0]       k_reg, k_next;
    logic             sin_pass_reg, sin_pass_next;
    logic [30:0]      c_reg, c_next;
    logic             cos_neg_reg, cos_neg_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [6:0]       rem_reg, rem_next;
    logic [5:0]       div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [SUM_W:0]   sum_add;
    logic [29:0]      frac;
    logic [29:0]      frac_fold;
    logic [30:0]      frac_diff;
    logic [6:0]       divisor;
    logic [31:0]      resid;
    logic [31:0]      quot;
    logic [30:0]      h_new;
    logic [30:0]      sin_val;
    logic [30:0]      cc;
    logic [30:0]      ss;
    logic [30:0]      cos_mag;
    logic             cos_neg;
    logic [30:0]      pm;
    logic [22:0]      div_x;
    logic [15:0]      div_q;
    logic [6:0]       div_r;
    logic [16:0]      pf;
    logic [39:0]      value;

    assign result.valid           = out_valid_reg;
    assign result.objective_value = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        cp_mag_next    = cp_mag_reg;
        cp_neg_next    = cp_neg_reg;
        quad_next      = quad_reg;
        swap_next      = swap_reg;
        th_next        = th_reg;
        t2_next        = t2_reg;
        h_next         = h_reg;
        m_next         = m_reg;
        q0_next        = q0_reg;
        k_next         = k_reg;
        sin_pass_next  = sin_pass_reg;
        c_next         = c_reg;
        cos_neg_next   = cos_neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        pop            = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(prod_reg[53:FRAC_BITS]);
        frac      = prod_reg[45:16];
        frac_diff = Q30_ONE - {1'b0, frac};
        frac_fold = (frac > 30'h2000_0000) ? frac_diff[29:0] : frac;
        divisor   = sin_pass_reg ? SIN_DIV[k_reg] : COS_DIV[k_reg];
        resid     = {2'b0, m_reg} - prod_reg[31:0];
        quot      = (resid >= {25'b0, divisor}) ? q0_reg + 32'd1 : q0_reg;
        h_new     = Q30_ONE - quot[30:0];
        sin_val   = prod_reg[60:30];
        cc        = swap_reg ? sin_val : c_reg;
        ss        = swap_reg ? c_reg : sin_val;
        pm        = prod_reg[60:30];
        div_x     = {rem_reg, quo_reg[SUM_W-1:SUM_W-16]};
        div_q     = prod_reg[45:30];
        div_r     = 7'(div_x - 23'(div_q) * 23'(SUM_ODD_DIV));
        pf        = 17'(cp_mag_reg >> (30 - FRAC_BITS));
        if (cp_neg_reg)
        begin
            value = quo_reg[39:0] + 40'h1_0000 + 40'(pf);
        end
        else
        begin
            value = quo_reg[39:0] + 40'h1_0000 - 40'(pf);
        end

        case (quad_reg)
            2'd0:
            begin
                cos_mag = cc;
                cos_neg = 1'b0;
            end
            2'd1:
            begin
                cos_mag = ss;
                cos_neg = 1'b1;
            end
            2'd2:
            begin
                cos_mag = cc;
                cos_neg = 1'b1;
            end
            default:
            begin
                cos_mag = ss;
                cos_neg = 1'b0;
            end
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    mag_next   = job.mag;
                    idx_next   = job.idx;
                    last_next  = job.last;
                    mul_a      = {5'b0, job.mag};
                    mul_b      = {5'b0, job.mag};
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sum_next   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                mul_a      = {5'b0, mag_reg};
                mul_b      = {1'b0, RSQRT_ROM[idx_reg]};
                state_next = ST_ANG;
            end
            ST_ANG:
            begin
                mul_a      = {5'b0, prod_reg[56:30]};
                mul_b      = INV_TWO_PI;
                state_next = ST_PH;
            end
            ST_PH:
            begin
                quad_next  = prod_reg[47:46];
                swap_next  = frac > 30'h2000_0000;
                mul_a      = {2'b0, frac_fold};
                mul_b      = HALF_PI_Q30;
                state_next = ST_TH;
            end
            ST_TH:
            begin
                th_next    = prod_reg[59:30];
                mul_a      = {2'b0, prod_reg[59:30]};
                mul_b      = {2'b0, prod_reg[59:30]};
                state_next = ST_T2;
            end
            ST_T2:
            begin
                t2_next       = prod_reg[59:30];
                h_next        = Q30_ONE;
                k_next        = '0;
                sin_pass_next = 1'b0;
                state_next    = ST_HMUL;
            end
            ST_HMUL:
            begin
                mul_a      = {2'b0, t2_reg};
                mul_b      = {1'b0, h_reg};
                state_next = ST_HREC;
            end
            ST_HREC:
            begin
                m_next     = prod_reg[59:30];
                mul_a      = {2'b0, prod_reg[59:30]};
                mul_b      = sin_pass_reg ? SIN_RECIP[k_reg] : COS_RECIP[k_reg];
                state_next = ST_HBACK;
            end
            ST_HBACK:
            begin
                q0_next    = prod_reg[63:32];
                mul_a      = prod_reg[63:32];
                mul_b      = {25'b0, divisor};
                state_next = ST_HFIX;
            end
            ST_HFIX:
            begin
                if (k_reg == 3'(HORNER_LEN - 1))
                begin
                    k_next = '0;
                    if (!sin_pass_reg)
                    begin
                        c_next        = h_new;
                        h_next        = Q30_ONE;
                        sin_pass_next = 1'b1;
                        state_next    = ST_HMUL;
                    end
                    else
                    begin
                        h_next     = h_new;
                        state_next = ST_SMUL;
                    end
                end
                else
                begin
                    h_next     = h_new;
                    k_next     = k_reg + 3'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_SMUL:
            begin
                mul_a      = {2'b0, th_reg};
                mul_b      = {1'b0, h_reg};
                state_next = ST_SIN;
            end
            ST_SIN:
            begin
                cos_neg_next = cos_neg && (cos_mag != '0);
                mul_a        = {1'b0, cp_mag_reg};
                mul_b        = {1'b0, cos_mag};
                state_next   = ST_PROD;
            end
            ST_PROD:
            begin
                cp_mag_next = pm;
                cp_neg_next = (cp_neg_reg ^ cos_neg_reg) && (pm != '0);
                if (last_reg)
                begin
                    quo_next     = sum_reg >> SUM_SHIFT;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 6'd1;
                if (!div_cnt_reg[0])
                begin
                    mul_a = {9'b0, div_x};
                    mul_b = {8'b0, SUM_RECIP};
                end
                else
                begin
                    rem_next = div_r;
                    quo_next = {quo_reg[SUM_W-17:0], div_q};
                    if (div_cnt_reg == 6'(2 * DIV_CHUNKS - 1))
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = (value > OUT_MAX) ? '1 : value[OUT_W-1:0];
                    sum_next       = '0;
                    cp_mag_next    = Q30_ONE;
                    cp_neg_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        quad_reg    <= quad_next;
        swap_reg    <= swap_next;
        th_reg      <= th_next;
        t2_reg      <= t2_next;
        h_reg       <= h_next;
        m_reg       <= m_next;
        q0_reg      <= q0_next;
        c_reg       <= c_next;
        cos_neg_reg <= cos_neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            cp_mag_reg    <= Q30_ONE;
            cp_neg_reg    <= 1'b0;
            k_reg         <= '0;
            sin_pass_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cp_mag_reg    <= cp_mag_next;
            cp_neg_reg    <= cp_neg_next;
            k_reg         <= k_next;
            sin_pass_reg  <= sin_pass_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/griewank_objective_evaluator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// griewank_objective_evaluator
// Griewank function of a vector that arrives one Q11.16 coordinate per item.
// ----------------------------------------------------------------------------
// The back end takes a new coordinate only when it is through with the last
// one. The last coordinate of a vector also goes through the divide of the
// square sum by 4000 in three 16-bit digits and then the load of the result
// register. The back end runs on the single shared 32x32 multiplier, which
// steps through the square, the scaled angle, the cosine and sine series, the
// product update and the digit divide. A two-entry queue lets the input side
// take up to two coordinates ahead, and the result register lets a finished
// value wait while work continues. The user must write the vector length
// through the configuration channel only while the block is idle; the block
// does not enforce this. Zero acts as one and values above 64 act as 64.
module griewank_objective_evaluator import gge_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    gge_coord_if.sink    coord,
    gge_result_if.source result,
    gge_cfg_if.sink      cfg
);

    logic     push;
    logic     queue_full;
    logic     pop;
    logic     job_valid;
    gge_job_t push_job;
    gge_job_t job;

    gge_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coord      (coord),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    gge_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .job_valid (job_valid),
        .job       (job)
    );

    gge_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire
